@@ rtl/dgsp_pkg.sv @@
// Shared types and constants for the dense-graph shortest path block.
// Used by dgsp_ctrl, dgsp_datapath and dense_graph_shortest_paths.
package dgsp_pkg;

    localparam int VTX_BITS = 4;
    localparam int WIN_BITS = 16;
    localparam int LEN_BITS = 20;
    localparam int CFG_BITS = 5;

    localparam logic [LEN_BITS-1:0] LEN_MAX   = 20'hFFFFF;
    localparam logic [CFG_BITS-1:0] NODES_RST = 5'd16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_FIND,
        S_SETTLE,
        S_RELAX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic run_start;
        logic init_rd;
        logic find_step;
        logic find_first;
        logic settle;
        logic relax_rd;
        logic emit;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic found;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/dgsp_datapath.sv @@
// Datapath: weight matrix memory, distance and settled registers, minimum search,
// relaxation adder and output register. Depends on dgsp_pkg; driven by dgsp_ctrl.
module dgsp_datapath import dgsp_pkg::*; #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [$clog2(MAX_NODES)-1:0] i_idx,
    input  logic [VTX_BITS-1:0]  i_row_vertex,
    input  logic [VTX_BITS-1:0]  i_col_vertex,
    input  logic [WIN_BITS-1:0]  i_edge_weight,
    input  logic [VTX_BITS-1:0]  i_source_vertex,
    input  logic                 i_out_stall,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic [VTX_BITS-1:0]  o_vertex,
    output logic [LEN_BITS-1:0]  o_path_length,
    output logic                 o_reachable,
    output logic                 o_last
);

    localparam int IW        = $clog2(MAX_NODES);
    localparam int AW        = 2 * IW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int DW        = WEIGHT_BITS + IW + 1;

    // upper triangle only: an undirected edge lives at {min, max}
    logic [WEIGHT_BITS-1:0] r_mem [MEM_DEPTH];
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic [AW-1:0]          r_clr_cnt;

    logic [DW-1:0]          r_dist [MAX_NODES];
    logic [MAX_NODES-1:0]   r_inf;
    logic [MAX_NODES-1:0]   r_set;
    logic [IW-1:0]          r_src;
    logic [IW-1:0]          r_pick;
    logic [DW-1:0]          r_near;
    logic                   r_found;
    logic                   r_pend_init;
    logic                   r_pend_relax;
    logic [IW-1:0]          r_pend_idx;

    logic                   r_o_valid;
    logic [VTX_BITS-1:0]    r_o_vertex;
    logic [LEN_BITS-1:0]    r_o_len;
    logic                   r_o_reach;
    logic                   r_o_last;

    logic [IW-1:0]          wr_row;
    logic [IW-1:0]          wr_col;
    logic                   wr_ok;
    logic [AW-1:0]          wr_addr;
    logic [IW-1:0]          rd_sel;
    logic [AW-1:0]          rd_addr;
    logic [DW-1:0]          cand;
    logic                   relax_upd;
    logic                   find_take;
    logic                   found_eff;
    logic                   len_sat;

    always_comb begin
        wr_row  = IW'(i_row_vertex);
        wr_col  = IW'(i_col_vertex);
        wr_ok   = (32'(i_row_vertex) < MAX_NODES) && (32'(i_col_vertex) < MAX_NODES);
        wr_addr = (wr_row < wr_col) ? {wr_row, wr_col} : {wr_col, wr_row};
        rd_sel  = i_cmd.init_rd ? r_src : r_pick;
        rd_addr = (rd_sel < i_idx) ? {rd_sel, i_idx} : {i_idx, rd_sel};

        cand      = r_near + DW'(r_rd_data);
        relax_upd = !r_set[r_pend_idx] && (r_rd_data != '0) &&
                    (r_inf[r_pend_idx] || (cand < r_dist[r_pend_idx]));

        found_eff = i_cmd.find_first ? 1'b0 : r_found;
        find_take = !r_set[i_idx] && !r_inf[i_idx] &&
                    (!found_eff || (r_dist[i_idx] < r_near));

        len_sat = 64'(r_dist[i_idx]) > 64'(LEN_MAX);

        o_stat.clear_last = &r_clr_cnt;
        o_stat.found      = r_found;
        o_stat.out_free   = !r_o_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.load && wr_ok) begin
            r_mem[wr_addr] <= WEIGHT_BITS'(i_edge_weight);
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_set        <= '0;
            r_found      <= 1'b0;
            r_pend_init  <= 1'b0;
            r_pend_relax <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            r_pend_init  <= i_cmd.init_rd;
            r_pend_relax <= i_cmd.relax_rd;
            if (i_cmd.run_start) begin
                r_set <= MAX_NODES'(1) << IW'(i_source_vertex);
            end
            if (i_cmd.settle) begin
                r_set[r_pick] <= 1'b1;
            end
            if (i_cmd.find_step) begin
                if (find_take) begin
                    r_found <= 1'b1;
                end else if (i_cmd.find_first) begin
                    r_found <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= i_idx;
        if (i_cmd.run_start) begin
            r_src <= IW'(i_source_vertex);
        end
        if (i_cmd.find_step && find_take) begin
            r_near <= r_dist[i_idx];
            r_pick <= i_idx;
        end
        if (r_pend_init) begin
            if (r_pend_idx == r_src) begin
                r_dist[r_pend_idx] <= '0;
                r_inf[r_pend_idx]  <= 1'b0;
            end else begin
                r_dist[r_pend_idx] <= DW'(r_rd_data);
                r_inf[r_pend_idx]  <= (r_rd_data == '0);
            end
        end else if (r_pend_relax && relax_upd) begin
            r_dist[r_pend_idx] <= cand;
            r_inf[r_pend_idx]  <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_o_vertex <= VTX_BITS'(i_idx);
            r_o_reach  <= !r_inf[i_idx];
            r_o_last   <= i_cmd.emit_last;
            if (r_inf[i_idx]) begin
                r_o_len <= '0;
            end else if (len_sat) begin
                r_o_len <= LEN_MAX;
            end else begin
                r_o_len <= LEN_BITS'(r_dist[i_idx]);
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_vertex      = r_o_vertex;
    assign o_path_length = r_o_len;
    assign o_reachable   = r_o_reach;
    assign o_last        = r_o_last;

endmodule

@@ rtl/dgsp_ctrl.sv @@
// Controller: sequences memory clear, loads, and the init/find/relax/output scans.
// Depends on dgsp_pkg; issues t_cmd to dgsp_datapath and reads t_stat back.
module dgsp_ctrl import dgsp_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [VTX_BITS-1:0]  i_source_vertex,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    input  t_stat                i_stat,
    output t_cmd                 o_cmd,
    output logic [$clog2(MAX_NODES)-1:0] o_idx
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    t_state              r_state, n_state;
    logic [IW-1:0]       r_j, n_j;
    logic [CFG_BITS-1:0] r_node_count;

    logic [CW-1:0]       nodes;
    logic                accept;
    logic                run_ok;
    logic                j_last;

    always_comb begin
        nodes  = (32'(r_node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(r_node_count);
        accept = i_in_valid && !o_in_stall;
        run_ok = (i_command == CMD_RUN) && (32'(i_source_vertex) < 32'(nodes));
        j_last = (32'(r_j) + 1) == 32'(nodes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_j          <= '0;
            r_node_count <= NODES_RST;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                n_j        = '0;
                if (accept) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (run_ok) begin
                        o_cmd.run_start = 1'b1;
                        n_state         = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_rd = 1'b1;
                n_j           = r_j + 1'b1;
                if (j_last) begin
                    n_j     = '0;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find_step  = 1'b1;
                o_cmd.find_first = (r_j == '0);
                n_j              = r_j + 1'b1;
                if (j_last) begin
                    n_j     = '0;
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                // a round that finds nothing ends the search
                if (i_stat.found) begin
                    o_cmd.settle = 1'b1;
                    n_state      = S_RELAX;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RELAX: begin
                o_cmd.relax_rd = 1'b1;
                n_j            = r_j + 1'b1;
                if (j_last) begin
                    n_j     = '0;
                    n_state = S_FIND;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = j_last;
                    n_j             = r_j + 1'b1;
                    if (j_last) begin
                        n_j     = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idx = r_j;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result issued into a full output register");

    a_settle_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.settle |-> i_stat.found)
        else $error("vertex settled without a find hit");

    a_run_enters_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.run_start |=> (r_state == S_INIT) && (r_j == '0))
        else $error("run transaction did not start the init scan");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("last result did not end the run");

endmodule

@@ rtl/dense_graph_shortest_paths.sv @@
// Dense-graph single-source shortest paths over a weight matrix memory.
// Load transaction: writes one edge weight. Run: accept, an init scan over n
// vertices, then per settled vertex a find scan, a settle and a relax scan, then a
// final find that settles nothing, then n results (one per cycle when not stalled).
// Scans step one vertex per cycle. Reset: synchronous; a clearing pass zeroes the
// matrix with input stall high, then the block is idle with node_count 16.
module dense_graph_shortest_paths import dgsp_pkg::*; #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [VTX_BITS-1:0] i_row_vertex,
    input  logic [VTX_BITS-1:0] i_col_vertex,
    input  logic [WIN_BITS-1:0] i_edge_weight,
    input  logic [VTX_BITS-1:0] i_source_vertex,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VTX_BITS-1:0] o_vertex,
    output logic [LEN_BITS-1:0] o_path_length,
    output logic                o_reachable,
    output logic                o_last
);

    localparam int IW = $clog2(MAX_NODES);

    t_cmd          cmd;
    t_stat         stat;
    logic [IW-1:0] idx;

    dgsp_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_source_vertex (i_source_vertex),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_stat          (stat),
        .o_cmd           (cmd),
        .o_idx           (idx)
    );

    dgsp_datapath #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .i_row_vertex    (i_row_vertex),
        .i_col_vertex    (i_col_vertex),
        .i_edge_weight   (i_edge_weight),
        .i_source_vertex (i_source_vertex),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_vertex        (o_vertex),
        .o_path_length   (o_path_length),
        .o_reachable     (o_reachable),
        .o_last          (o_last)
    );

endmodule
